/* rtl/core/ypsc_pkg.sv */
package ypsc_pkg;

  localparam logic [3:0] P_START = 4'd0;
  localparam logic [3:0] P_DEAD  = 4'd15;

  // float recognizer
  localparam logic [3:0] F_SIGNED = 4'd1;
  localparam logic [3:0] F_INT    = 4'd2;
  localparam logic [3:0] F_LDOT   = 4'd3;
  localparam logic [3:0] F_FRAC   = 4'd4;
  localparam logic [3:0] F_EXP    = 4'd5;
  localparam logic [3:0] F_EXPS   = 4'd6;
  localparam logic [3:0] F_EXPD   = 4'd7;

  // sexagesimal recognizer
  localparam logic [3:0] S_SIGNED = 4'd1;
  localparam logic [3:0] S_INT    = 4'd2;
  localparam logic [3:0] S_COLON  = 4'd3;
  localparam logic [3:0] S_G1LOW  = 4'd4;
  localparam logic [3:0] S_G1HIGH = 4'd5;
  localparam logic [3:0] S_G2     = 4'd6;
  localparam logic [3:0] S_FRAC   = 4'd7;

  // radix recognizer
  localparam logic [3:0] R_SIGNED = 4'd1;
  localparam logic [3:0] R_ZERO   = 4'd2;
  localparam logic [3:0] R_BPRE   = 4'd3;
  localparam logic [3:0] R_BIN    = 4'd4;
  localparam logic [3:0] R_XPRE   = 4'd5;
  localparam logic [3:0] R_HEX    = 4'd6;
  localparam logic [3:0] R_OCT    = 4'd7;
  localparam logic [3:0] R_DEC    = 4'd8;

  localparam logic [2:0] RADIX_NONE = 3'd0;
  localparam logic [2:0] RADIX_BIN  = 3'd1;
  localparam logic [2:0] RADIX_OCT  = 3'd2;
  localparam logic [2:0] RADIX_DEC  = 3'd3;
  localparam logic [2:0] RADIX_HEX  = 3'd4;

  localparam int unsigned StoreDepth = 6;
  localparam logic [2:0]  CountMax   = 3'd7;

  typedef struct packed {
    logic [2:0]                  count;
    logic [StoreDepth-1:0][7:0]  store;
    logic                        sign;
    logic [3:0]                  fph;
    logic [3:0]                  cph;
    logic [3:0]                  rph;
  } st_t;

  // packed from the top so that the lowest bit is is_bool
  typedef struct packed {
    logic [1:0] digits_start;
    logic [2:0] int_radix;
    logic       is_sexagesimal;
    logic       is_non_finite;
    logic       is_float;
    logic       is_null;
    logic       bool_value;
    logic       is_bool;
  } res_t;

  function automatic logic is_dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_sign(logic [7:0] c);
    return c == "+" || c == "-";
  endfunction

  // w holds the spelling right-justified, first character in the highest used byte
  function automatic logic match_at(logic [StoreDepth-1:0][7:0] st, logic [2:0] cnt,
                                    logic off, logic [47:0] w, logic [2:0] len);
    logic       ok;
    logic [3:0] idx;
    logic [7:0] ch;
    ok = (4'(cnt) == 4'(off) + 4'(len)) && (4'(off) + 4'(len) <= 4'(StoreDepth));
    for (int i = 0; i < StoreDepth; i++) begin
      idx = 4'(off) + 4'(i);
      ch  = 8'(w >> (8 * (int'(len) - 1 - i)));
      if (i < int'(len) && idx < 4'(StoreDepth)) begin
        if (st[idx[2:0]] != ch) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [3:0] next_float(logic [3:0] p, logic [7:0] c);
    logic [3:0] n;
    case (p)
      P_START:  n = is_sign(c) ? F_SIGNED : is_dec(c) ? F_INT : (c == ".") ? F_LDOT : P_DEAD;
      F_SIGNED: n = is_dec(c) ? F_INT : P_DEAD;
      F_INT:    n = (is_dec(c) || c == "_") ? F_INT : (c == ".") ? F_FRAC : P_DEAD;
      F_LDOT:   n = is_dec(c) ? F_FRAC : P_DEAD;
      F_FRAC:   n = (is_dec(c) || c == "_") ? F_FRAC :
                    (c == "e" || c == "E") ? F_EXP : P_DEAD;
      F_EXP:    n = is_sign(c) ? F_EXPS : P_DEAD;
      F_EXPS,
      F_EXPD:   n = is_dec(c) ? F_EXPD : P_DEAD;
      default:  n = P_DEAD;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] next_colon(logic [3:0] p, logic [7:0] c);
    logic [3:0] n;
    case (p)
      P_START:  n = is_sign(c) ? S_SIGNED : is_dec(c) ? S_INT : P_DEAD;
      S_SIGNED: n = is_dec(c) ? S_INT : P_DEAD;
      S_INT:    n = (is_dec(c) || c == "_") ? S_INT : (c == ":") ? S_COLON : P_DEAD;
      S_COLON:  n = !is_dec(c) ? P_DEAD : (c <= "5") ? S_G1LOW : S_G1HIGH;
      S_G1LOW,
      S_G1HIGH,
      S_G2: begin
        if (is_dec(c)) n = (p == S_G1LOW) ? S_G2 : P_DEAD;
        else           n = (c == ":") ? S_COLON : (c == ".") ? S_FRAC : P_DEAD;
      end
      S_FRAC:   n = (is_dec(c) || c == "_") ? S_FRAC : P_DEAD;
      default:  n = P_DEAD;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] next_radix(logic [3:0] p, logic [7:0] c);
    logic [3:0] n;
    logic [3:0] first;
    first = (c == "0") ? R_ZERO : (c >= "1" && c <= "9") ? R_DEC : P_DEAD;
    case (p)
      P_START:  n = is_sign(c) ? R_SIGNED : first;
      R_SIGNED: n = first;
      R_ZERO:   n = (c == "b") ? R_BPRE : (c == "x") ? R_XPRE :
                    (is_oct(c) || c == "_") ? R_OCT : P_DEAD;
      R_BPRE,
      R_BIN:    n = (c == "0" || c == "1" || c == "_") ? R_BIN : P_DEAD;
      R_XPRE,
      R_HEX:    n = (is_hex(c) || c == "_") ? R_HEX : P_DEAD;
      R_OCT:    n = (is_oct(c) || c == "_") ? R_OCT : P_DEAD;
      R_DEC:    n = (is_dec(c) || c == "_") ? R_DEC : P_DEAD;
      default:  n = P_DEAD;
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/ypsc_classify.sv */
module ypsc_classify (
  input  ypsc_pkg::st_t  cur_i,
  input  logic [7:0]     char_i,
  input  logic           empty_i,
  output ypsc_pkg::st_t  nxt_o,
  output ypsc_pkg::res_t res_o
);

  ypsc_pkg::st_t upd;
  ypsc_pkg::st_t fin;
  logic          is_true;
  logic          is_false;

  always_comb begin
    upd = cur_i;
    if (cur_i.count == 3'd0 && ypsc_pkg::is_sign(char_i)) upd.sign = 1'b1;
    upd.fph = ypsc_pkg::next_float(cur_i.fph, char_i);
    upd.cph = ypsc_pkg::next_colon(cur_i.cph, char_i);
    upd.rph = ypsc_pkg::next_radix(cur_i.rph, char_i);
    for (int i = 0; i < ypsc_pkg::StoreDepth; i++) begin
      if (cur_i.count == 3'(i)) upd.store[i] = char_i;
    end
    if (cur_i.count != ypsc_pkg::CountMax) upd.count = cur_i.count + 3'd1;
  end

  assign nxt_o = upd;
  // an empty item adds nothing, the result describes what came before
  assign fin   = empty_i ? cur_i : upd;

  always_comb begin
    is_true =
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("yes"), 3'd3) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("Yes"), 3'd3) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("YES"), 3'd3) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("true"), 3'd4) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("True"), 3'd4) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("TRUE"), 3'd4) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("on"), 3'd2) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("On"), 3'd2) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("ON"), 3'd2);
    is_false =
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("no"), 3'd2) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("No"), 3'd2) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("NO"), 3'd2) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("false"), 3'd5) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("False"), 3'd5) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("FALSE"), 3'd5) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("off"), 3'd3) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("Off"), 3'd3) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("OFF"), 3'd3);

    res_o.is_bool    = is_true || is_false;
    res_o.bool_value = is_true;
    res_o.is_null    = (fin.count == 3'd0) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("~"), 3'd1) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("null"), 3'd4) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("Null"), 3'd4) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'("NULL"), 3'd4);
    // inf may carry a sign, nan may not
    res_o.is_non_finite =
      ypsc_pkg::match_at(fin.store, fin.count, fin.sign, 48'(".inf"), 3'd4) ||
      ypsc_pkg::match_at(fin.store, fin.count, fin.sign, 48'(".Inf"), 3'd4) ||
      ypsc_pkg::match_at(fin.store, fin.count, fin.sign, 48'(".INF"), 3'd4) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'(".nan"), 3'd4) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'(".NaN"), 3'd4) ||
      ypsc_pkg::match_at(fin.store, fin.count, 1'b0, 48'(".NAN"), 3'd4);
    res_o.is_float = (fin.fph == ypsc_pkg::F_FRAC) || (fin.fph == ypsc_pkg::F_EXPD);
    res_o.is_sexagesimal = (fin.cph == ypsc_pkg::S_G1LOW) || (fin.cph == ypsc_pkg::S_G1HIGH) ||
                           (fin.cph == ypsc_pkg::S_G2) || (fin.cph == ypsc_pkg::S_FRAC);
    case (fin.rph)
      ypsc_pkg::R_BIN: begin
        res_o.int_radix    = ypsc_pkg::RADIX_BIN;
        res_o.digits_start = 2'(fin.sign) + 2'd2;
      end
      ypsc_pkg::R_OCT: begin
        res_o.int_radix    = ypsc_pkg::RADIX_OCT;
        res_o.digits_start = 2'(fin.sign);
      end
      ypsc_pkg::R_ZERO,
      ypsc_pkg::R_DEC: begin
        res_o.int_radix    = ypsc_pkg::RADIX_DEC;
        res_o.digits_start = 2'(fin.sign);
      end
      ypsc_pkg::R_HEX: begin
        res_o.int_radix    = ypsc_pkg::RADIX_HEX;
        res_o.digits_start = 2'(fin.sign) + 2'd2;
      end
      default: begin
        res_o.int_radix    = ypsc_pkg::RADIX_NONE;
        res_o.digits_start = 2'd0;
      end
    endcase
  end

endmodule

/* rtl/core/yaml_plain_scalar_classifier.sv */
// Plain scalar shape classifier, one text byte per cycle while no scalar end waits on a stalled result.
// Path: the request carrying the last character (or the empty flag) is held in the input
// register, then its result is loaded into the result register.
// Throughput: one request per cycle; a request ending a scalar waits in the input
// register only while the result register is full and stalled.
// Reset (rst_ni low, asynchronous) clears the handshake flags and the recognizer state.
module yaml_plain_scalar_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] char_code
  input  logic        s_axis_tlast_i,  // last_char
  input  logic        s_axis_tuser_i,  // empty_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // [0] is_bool, [1] bool_value, [2] is_null,
                                       // [3] is_float, [4] is_non_finite,
                                       // [5] is_sexagesimal, [8:6] int_radix,
                                       // [10:9] digits_start, [15:11] zero
);

  logic           in_valid_q, in_valid_d;
  logic [7:0]     in_char_q;
  logic           in_last_q;
  logic           in_empty_q;
  logic           in_end;
  logic           in_adv;
  logic           res_load;
  logic           out_valid_q, out_valid_d;
  ypsc_pkg::res_t out_res_q;
  ypsc_pkg::st_t  st_q, st_d;
  ypsc_pkg::st_t  st_nxt;
  ypsc_pkg::res_t res;

  assign in_end          = in_empty_q || in_last_q;
  assign in_adv          = in_valid_q && (!in_end || !out_valid_q || m_axis_tready_i);
  assign res_load        = in_adv && in_end;
  assign s_axis_tready_o = !in_valid_q || in_adv;

  ypsc_classify u_classify (
    .cur_i   (st_q),
    .char_i  (in_char_q),
    .empty_i (in_empty_q),
    .nxt_o   (st_nxt),
    .res_o   (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) in_valid_d = s_axis_tvalid_i;

    st_d = st_q;
    if (res_load) begin
      st_d       = '0;
      st_d.fph   = ypsc_pkg::P_START;
      st_d.cph   = ypsc_pkg::P_START;
      st_d.rph   = ypsc_pkg::P_START;
    end else if (in_adv) begin
      st_d = st_nxt;
    end

    out_valid_d = out_valid_q;
    if (res_load)             out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q  <= s_axis_tdata_i;
      in_last_q  <= s_axis_tlast_i;
      in_empty_q <= s_axis_tuser_i;
    end
    if (res_load) out_res_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_res_q};

  // a finished scalar always leaves the recognizers at their start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (st_q.count == 3'd0) && (st_q.sign == 1'b0) &&
                 (st_q.rph == ypsc_pkg::P_START))
    else $error("recognizer state not cleared after result");

  // a held input request must not be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_adv) |=> in_valid_q && $stable(in_char_q) && $stable(in_last_q))
    else $error("pending input request lost");

  // a pending result must not be replaced before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !res_load)
    else $error("result overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_res_q.bool_value || out_res_q.is_bool) &&
                    (out_res_q.int_radix != ypsc_pkg::RADIX_NONE ||
                     out_res_q.digits_start == 2'd0))
    else $error("dependent result field set without its flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.is_float |-> out_res_q.int_radix == ypsc_pkg::RADIX_NONE)
    else $error("float text also flagged as integer");

endmodule
